@@ hw/rtl/life_grid_generation_step_defines.svh @@
// Assertion macros for the life grid generation step checker.
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

// Antecedent and consequent checked at the same edge.
`define LGS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lgs checker: property failed");

// Consequent checked from the edge after the antecedent.
`define LGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lgs checker: property failed");

`endif

@@ hw/rtl/lgs_pkg.sv @@
// Package: grid geometry, request codes, controller states and memory request type.
`timescale 1ns / 1ps

package lgs_pkg;

	localparam int ROWS   = 128;
	localparam int COLS   = 128;
	localparam int ROW_AW = $clog2(ROWS);
	localparam int COL_AW = $clog2(COLS);

	typedef logic [COLS-1:0]   row_bits_t;
	typedef logic [ROW_AW-1:0] row_addr_t;
	typedef logic [COL_AW-1:0] col_addr_t;

	typedef enum logic [1:0] {
		REQ_FLIP = 2'd0,
		REQ_STEP = 2'd1,
		REQ_READ = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_GEN_LOAD,
		ST_GEN_ROW,
		ST_GEN_DONE
	} state_t;

	typedef struct packed {
		logic      rd_en;
		row_addr_t rd_addr;
		logic      wr_en;
		row_addr_t wr_addr;
		row_bits_t wr_data;
	} ram_req_t;

	// Reset pattern of one row: alive where row + column is even.
	function automatic row_bits_t checker_row(input logic odd_row);
		row_bits_t r;
		for (int c = 0; c < COLS; c++) begin
			r[c] = ~(c[0] ^ odd_row);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/lgs_row_ram.sv @@
// Row-wide grid memory: one write and one registered read per cycle.
`timescale 1ns / 1ps

module lgs_row_ram (
	input  logic              clk,
	input  lgs_pkg::ram_req_t req,
	output lgs_pkg::row_bits_t rd_data
);

	lgs_pkg::row_bits_t mem [lgs_pkg::ROWS];
	lgs_pkg::row_bits_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ hw/rtl/lgs_row_update.sv @@
// Next-generation row from the old rows above, at and below (B3/S23, dead border).
`timescale 1ns / 1ps

module lgs_row_update (
	input  lgs_pkg::row_bits_t above,
	input  lgs_pkg::row_bits_t cur,
	input  lgs_pkg::row_bits_t below,
	output lgs_pkg::row_bits_t next_row
);

	// Dead column padded on each side.
	logic [lgs_pkg::COLS+1:0] a_p, c_p, b_p;

	assign a_p = {1'b0, above, 1'b0};
	assign c_p = {1'b0, cur, 1'b0};
	assign b_p = {1'b0, below, 1'b0};

	for (genvar c = 0; c < lgs_pkg::COLS; c++) begin : g_lane
		logic [3:0] cnt;
		assign cnt = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
			+ 4'(c_p[c]) + 4'(c_p[c+2])
			+ 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
		assign next_row[c] = (cnt == 4'd3) || (c_p[c+1] && (cnt == 4'd2));
	end

endmodule

@@ hw/rtl/life_grid_generation_step.sv @@
// Top level: Game of Life (B3/S23) grid held in a row-wide memory, with flip, step and read
// requests. The grid sits in a single-port-write, registered-read memory of ROWS words of
// COLS bits each. After reset a clearing pass writes the checkerboard, one row a cycle, over
// all ROWS rows while in_ready stays low. A flip or read request first reads the addressed
// row, then forms the result (and writes the row back on a flip) once the output register is
// free. In a generation step the sweep writes one new row per cycle while prefetching the
// row two below, so the memory port sets the pace; the old row above and the old current
// row are kept in a two-row line buffer. Rows outside the grid count as dead. One request
// is in flight at a time; the result sits in an output register, and the next request is
// taken while it waits. A request whose row or column lies outside the grid changes nothing
// and returns 0; request type 3 behaves as a read.
`timescale 1ns / 1ps

module life_grid_generation_step (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	input  logic [6:0] row,
	input  logic [6:0] col,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       cell_value
);

	lgs_pkg::state_t    state_q, state_d;
	lgs_pkg::row_addr_t clr_q;      // clearing pass row
	lgs_pkg::row_addr_t gen_row_q;  // row being rewritten in the sweep

	// Request held for the whole operation.
	logic [1:0] req_q;
	logic [6:0] row_q;
	logic [6:0] col_q;

	// Line buffer: old values of the row above and of the current row.
	lgs_pkg::row_bits_t above_q, cur_q;

	logic out_valid_q;
	logic cell_value_q;

	lgs_pkg::ram_req_t  ram_req;
	lgs_pkg::row_bits_t rd_data;
	lgs_pkg::row_bits_t below;
	lgs_pkg::row_bits_t next_row;
	lgs_pkg::row_bits_t flip_mask;
	lgs_pkg::row_addr_t row_idx;
	lgs_pkg::col_addr_t col_idx;

	logic addr_ok;
	logic last_row;
	logic fetch_ok;
	logic clr_last;
	logic slot_free;
	logic accept;
	logic cell_done;
	logic cell_res;

	lgs_row_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	lgs_row_update u_update (
		.above    (above_q),
		.cur      (cur_q),
		.below    (below),
		.next_row (next_row)
	);

	assign addr_ok   = (int'(row_q) < lgs_pkg::ROWS) && (int'(col_q) < lgs_pkg::COLS);
	assign row_idx   = lgs_pkg::ROW_AW'(row_q);
	assign col_idx   = lgs_pkg::COL_AW'(col_q);
	assign flip_mask = lgs_pkg::row_bits_t'(1) << col_idx;

	assign last_row = (gen_row_q == lgs_pkg::row_addr_t'(lgs_pkg::ROWS - 1));
	assign fetch_ok = (int'(gen_row_q) + 2) < lgs_pkg::ROWS;
	assign clr_last = (clr_q == lgs_pkg::row_addr_t'(lgs_pkg::ROWS - 1));
	// Past the bottom row everything is dead.
	assign below    = last_row ? '0 : rd_data;

	assign slot_free = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign cell_res  = addr_ok && (rd_data[col_idx] ^ (req_q == lgs_pkg::REQ_FLIP));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lgs_pkg::ST_CLEAR: begin
				if (clr_last) state_d = lgs_pkg::ST_IDLE;
			end
			lgs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == lgs_pkg::REQ_STEP) ? lgs_pkg::ST_GEN_LOAD
						: lgs_pkg::ST_CELL;
				end
			end
			lgs_pkg::ST_CELL: begin
				if (slot_free) state_d = lgs_pkg::ST_IDLE;
			end
			lgs_pkg::ST_GEN_LOAD: begin
				state_d = lgs_pkg::ST_GEN_ROW;
			end
			lgs_pkg::ST_GEN_ROW: begin
				if (last_row) state_d = lgs_pkg::ST_GEN_DONE;
			end
			lgs_pkg::ST_GEN_DONE: begin
				state_d = lgs_pkg::ST_CELL;
			end
			default: state_d = lgs_pkg::ST_CLEAR;
		endcase
	end

	// Outputs: memory requests, handshake, result strobe
	always_comb begin
		ram_req   = '0;
		in_ready  = 1'b0;
		cell_done = 1'b0;
		unique case (state_q)
			lgs_pkg::ST_CLEAR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = clr_q;
				ram_req.wr_data = lgs_pkg::checker_row(clr_q[0]);
			end
			lgs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// A step starts by fetching row 0; flip and read fetch the addressed row.
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = (req_type == lgs_pkg::REQ_STEP) ? '0
						: lgs_pkg::ROW_AW'(row);
				end
			end
			lgs_pkg::ST_CELL: begin
				if (slot_free) begin
					cell_done = 1'b1;
					if ((req_q == lgs_pkg::REQ_FLIP) && addr_ok) begin
						ram_req.wr_en   = 1'b1;
						ram_req.wr_addr = row_idx;
						ram_req.wr_data = rd_data ^ flip_mask;
					end
				end
			end
			lgs_pkg::ST_GEN_LOAD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = lgs_pkg::row_addr_t'(1);
			end
			lgs_pkg::ST_GEN_ROW: begin
				// Write row r, prefetch row r+2 (never the row being written).
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = gen_row_q;
				ram_req.wr_data = next_row;
				if (fetch_ok) begin
					ram_req.rd_en   = 1'b1;
					ram_req.rd_addr = gen_row_q + lgs_pkg::row_addr_t'(2);
				end
			end
			lgs_pkg::ST_GEN_DONE: begin
				// Separate cycle so the read never meets the last row's write.
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = row_idx;
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lgs_pkg::ST_CLEAR;
			clr_q       <= '0;
			gen_row_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lgs_pkg::ST_CLEAR) clr_q <= clr_q + lgs_pkg::row_addr_t'(1);
			if (state_q == lgs_pkg::ST_GEN_LOAD) begin
				gen_row_q <= '0;
			end else if (state_q == lgs_pkg::ST_GEN_ROW) begin
				gen_row_q <= gen_row_q + lgs_pkg::row_addr_t'(1);
			end
			if (cell_done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_type;
			row_q <= row;
			col_q <= col;
		end
		if (state_q == lgs_pkg::ST_GEN_LOAD) begin
			above_q <= '0;
			cur_q   <= rd_data;
		end else if (state_q == lgs_pkg::ST_GEN_ROW) begin
			above_q <= cur_q;
			cur_q   <= below;
		end
		if (cell_done) cell_value_q <= cell_res;
	end

	assign out_valid  = out_valid_q;
	assign cell_value = cell_value_q;

endmodule

@@ hw/rtl/lgs_checker.sv @@
// Port-level checker for life_grid_generation_step, bound to the top level.
`timescale 1ns / 1ps
`include "life_grid_generation_step_defines.svh"

module lgs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] req_type,
	input logic       out_valid,
	input logic       out_ready,
	input logic       cell_value
);

	logic step_accept;

	assign step_accept = in_valid && in_ready && (req_type == lgs_pkg::REQ_STEP);

	// A stalled result holds.
	`LGS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cell_value))

	// One request at a time: ready drops right after an accept.
	`LGS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// A generation sweep keeps the input closed while it runs.
	`LGS_ASSERT_NEXT(a_step_busy, step_accept, !in_ready ##1 !in_ready ##1 !in_ready)

	// A new result only appears out of a busy cycle.
	`LGS_ASSERT_SAME(a_result_from_busy, $rose(out_valid), $past(!in_ready))

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.req_type   (req_type),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.cell_value (cell_value)
);
